FILE: src/etrd_pkg.sv
// ----------------------------------------------------------------------------
// etrd_pkg
// Shared types and constants of the edge timestamp run decoder.
// ----------------------------------------------------------------------------
package etrd_pkg;

	localparam int STAMP_W  = 8;
	localparam int RUN_W    = 24;
	localparam int CHAN_SEL_LSB = 4;

	localparam logic [STAMP_W-1:0] STAMP_MAX = 8'hFF;
	localparam logic [RUN_W-1:0]   RUN_MAX   = 24'hFFFFFF;

	typedef struct packed {
		logic             channel;
		logic             line_level;
		logic [RUN_W-1:0] run_length;
		logic             last;
	} run_t;

endpackage

FILE: src/etrd_byte_if.sv
// ----------------------------------------------------------------------------
// etrd_byte_if
// Valid/ready channel carrying one byte of the frame stream per transaction.
// ----------------------------------------------------------------------------
interface etrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

FILE: src/etrd_run_if.sv
// ----------------------------------------------------------------------------
// etrd_run_if
// Valid/ready channel carrying one decoded run per transaction.
// ----------------------------------------------------------------------------
interface etrd_run_if;
	logic        valid;
	logic        ready;
	logic        channel;
	logic        line_level;
	logic [23:0] run_length;
	logic        last;

	modport source(output valid, output channel, output line_level, output run_length,
		output last, input ready);
	modport sink(input valid, input channel, input line_level, input run_length,
		input last, output ready);
endinterface

FILE: src/etrd_out_buf.sv
// ----------------------------------------------------------------------------
// etrd_out_buf
// Two-entry result buffer: a head register that drives the run channel and a
// spare register that catches one more run while the receiver stalls.
// ----------------------------------------------------------------------------
module etrd_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  etrd_pkg::run_t  push_data,
	output logic            can_push,
	etrd_run_if.source      runs
);

	etrd_pkg::run_t head_q;
	etrd_pkg::run_t spare_q;
	logic           head_valid_q;
	logic           spare_valid_q;
	logic           pop;

	assign pop      = head_valid_q && runs.ready;
	assign can_push = !spare_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (pop) begin
			if (spare_valid_q) begin
				spare_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				spare_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (spare_valid_q) begin
				head_q <= spare_q;
				if (push) begin
					spare_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (head_valid_q) begin
				spare_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

	assign runs.valid      = head_valid_q;
	assign runs.channel    = head_q.channel;
	assign runs.line_level = head_q.line_level;
	assign runs.run_length = head_q.run_length;
	assign runs.last       = head_q.last;

endmodule

FILE: src/edge_timestamp_run_decoder.sv
// ----------------------------------------------------------------------------
// edge_timestamp_run_decoder
// Turns a framed stream of 8-bit edge timestamps into runs of line level.
// ----------------------------------------------------------------------------
// Usage:
//   bytes : one stream byte per transaction. Frames are FRAME_BYTES long; the
//           first HEADER_BYTES are header, bits 5:4 of header byte 1 select
//           the channel. Frames of channels 2 and 3 are consumed silently.
//   runs  : one run per transaction (channel, level, length). A changed
//           timestamp gives a run; a repeated one counts a wrap, and at frame
//           end two or more pending wraps give a run of whole 256-tick blocks.
//           A byte causes at most one run, so last is always 1.
// Throughput: one byte per clock while the output buffer has room; the per-channel
//   state update is done in the cycle the byte is accepted.
// Output: a run is registered into the output buffer when its byte is accepted.
// Stall: a two-entry output buffer holds runs; bytes keeps accepting while one
//   run waits and drops ready only when both entries are full.
// Reset: frame position, channel select, timestamps, wrap counts and levels
//   clear to zero; the output buffer empties.
// ----------------------------------------------------------------------------
module edge_timestamp_run_decoder #(
	parameter int FRAME_BYTES  = 64,
	parameter int HEADER_BYTES = 4,
	parameter int WRAP_WIDTH   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	etrd_byte_if.sink  bytes,
	etrd_run_if.source runs
);

	localparam int POS_W  = $clog2(FRAME_BYTES);
	localparam int FULL_W = WRAP_WIDTH + etrd_pkg::STAMP_W;
	localparam int EXT_W  = (FULL_W > etrd_pkg::RUN_W) ? FULL_W : etrd_pkg::RUN_W;

	logic [POS_W-1:0]             pos_q;
	logic [1:0]                   frame_chan_q;
	logic [etrd_pkg::STAMP_W-1:0] prev_q [2];
	logic [WRAP_WIDTH-1:0]        wrap_q [2];
	logic [1:0]                   level_q;

	logic                         accept;
	logic                         is_end;
	logic                         live;
	logic                         ch;
	logic [etrd_pkg::STAMP_W-1:0] stamp;
	logic [etrd_pkg::STAMP_W-1:0] prev;
	logic [etrd_pkg::STAMP_W-1:0] diff;
	logic [WRAP_WIDTH-1:0]        wraps;
	logic [WRAP_WIDTH-1:0]        wrap_inc;
	logic [WRAP_WIDTH-1:0]        wrap_next;
	logic [WRAP_WIDTH-1:0]        count_sel;
	logic [etrd_pkg::STAMP_W-1:0] low_sel;
	logic [FULL_W-1:0]            full_len;
	logic [EXT_W-1:0]             ext_len;
	logic                         same_stamp;
	logic                         fixup;
	logic                         end_run;
	logic                         emit;
	logic                         can_push;
	etrd_pkg::run_t               result;

	assign accept = bytes.valid && bytes.ready;
	assign is_end = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign live   = (pos_q >= POS_W'(HEADER_BYTES)) && !frame_chan_q[1];
	assign ch     = frame_chan_q[0];

	always_comb begin
		stamp      = bytes.stream_byte;
		prev       = prev_q[ch];
		wraps      = wrap_q[ch];
		same_stamp = (stamp == prev);
		diff       = stamp - prev;
		// saturate the wrap count
		wrap_inc   = (&wraps) ? wraps : wraps + WRAP_WIDTH'(1);
		fixup      = (wraps != '0) && ((stamp < prev) || (stamp == etrd_pkg::STAMP_MAX));
		end_run    = is_end && same_stamp && (wrap_inc > WRAP_WIDTH'(1));
		emit       = live && (!same_stamp || end_run);

		if (!same_stamp) begin
			wrap_next = '0;
		end else if (end_run) begin
			wrap_next = WRAP_WIDTH'(1);
		end else begin
			wrap_next = wrap_inc;
		end

		// a changed stamp runs (wraps-fixup)*256+diff, a frame-end flush (wrap_inc-1)*256
		count_sel = same_stamp ? wrap_inc - WRAP_WIDTH'(1) : wraps - WRAP_WIDTH'(fixup);
		low_sel   = same_stamp ? '0 : diff;
		full_len  = {count_sel, low_sel};
		ext_len   = EXT_W'(full_len);

		result.channel    = ch;
		result.line_level = level_q[ch];
		result.last       = 1'b1;
		if (ext_len > EXT_W'(etrd_pkg::RUN_MAX)) begin
			result.run_length = etrd_pkg::RUN_MAX;
		end else begin
			result.run_length = ext_len[etrd_pkg::RUN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			frame_chan_q <= '0;
			prev_q[0]    <= '0;
			prev_q[1]    <= '0;
			wrap_q[0]    <= '0;
			wrap_q[1]    <= '0;
			level_q      <= '0;
		end else if (accept) begin
			pos_q <= is_end ? '0 : pos_q + POS_W'(1);
			if (pos_q == POS_W'(1)) begin
				frame_chan_q <= stamp[etrd_pkg::CHAN_SEL_LSB +: 2];
			end
			if (live) begin
				wrap_q[ch] <= wrap_next;
				if (!same_stamp) begin
					prev_q[ch]  <= stamp;
					level_q[ch] <= !level_q[ch];
				end
			end
		end
	end

	assign bytes.ready = can_push;

	etrd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_data (result),
		.can_push  (can_push),
		.runs      (runs)
	);

endmodule

FILE: src/etrd_checker.sv
// ----------------------------------------------------------------------------
// etrd_checker
// Port-level checks of the edge timestamp run decoder, bound to the top level.
// ----------------------------------------------------------------------------
module etrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_run_length,
	input logic        out_last
);

	// hold a stalled run
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_run_length))
		else $error("stalled run dropped or changed");

	// every run stands alone for its byte
	a_last_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last)
		else $error("run without last");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_run_length != 24'd0)
		else $error("zero-length run");

	// a new run needs a byte accepted the cycle before
	a_run_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("run without accepted byte");

endmodule

bind edge_timestamp_run_decoder etrd_checker u_etrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (bytes.valid),
	.in_ready       (bytes.ready),
	.out_valid      (runs.valid),
	.out_ready      (runs.ready),
	.out_run_length (runs.run_length),
	.out_last       (runs.last)
);
